// ----- rtl/fdmr_pkg.sv -----
package fdmr_pkg;

  localparam int PIX_W       = 8;
  localparam int CNT_W       = 25;
  localparam int SUM_W       = 36;
  localparam int CFG_SIZE_W  = 13;
  localparam int CFG_DATA_W  = 25;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_COORD_W = 12;
  localparam int REGION_W    = 4;
  localparam int SIZE_EXT_W  = 15;
  localparam int DIV3_IN_W   = 17;
  localparam int COORD_BITS_DEF = 12;

  localparam logic [PIX_W-1:0]      PIX_MAX         = 8'd255;
  localparam logic [PIX_W-1:0]      DEF_THRESHOLD   = 8'd30;
  localparam logic [CNT_W-1:0]      DEF_MIN_CHANGED = 25'd100;
  localparam logic [CFG_SIZE_W-1:0] DEF_WIDTH       = 13'd640;
  localparam logic [CFG_SIZE_W-1:0] DEF_HEIGHT      = 13'd480;

  // 43691 / 2^17 is exact enough for floor(x / 3) over the whole 17-bit input
  localparam logic [15:0] RECIP3 = 16'd43691;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_THRESHOLD = 2'd0,
    CFG_MIN_CHANGED    = 2'd1,
    CFG_FRAME_WIDTH    = 2'd2,
    CFG_FRAME_HEIGHT   = 2'd3
  } cfg_idx_e_t;

  typedef enum logic {
    ST_PIXEL  = 1'b0,
    ST_DIVIDE = 1'b1
  } state_t;

  typedef struct packed {
    logic step;
    logic load_pix;
    logic div_start;
    logic load_div;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_motion;
    logic div_done;
  } dp_status_t;

  function automatic logic [DIV3_IN_W-1:0] div3(input logic [DIV3_IN_W-1:0] x);
    logic [DIV3_IN_W+15:0] prod;
    begin
      prod = {16'd0, x} * {{DIV3_IN_W{1'b0}}, RECIP3};
      return DIV3_IN_W'(prod[DIV3_IN_W+15:DIV3_IN_W]);
    end
  endfunction

endpackage

// ----- rtl/fdmr_div.sv -----
module fdmr_div
  import fdmr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dsr_r;

  logic [CNT_W:0]    rem_sh;
  logic              fits;
  logic [CNT_W:0]    rem_sub;
  logic [CNT_W-1:0]  rem_nxt;

  // one restoring step per cycle, most significant dividend bit first
  always_comb begin
    rem_sh  = {rem_r, quo_r[SUM_W-1]};
    fits    = rem_sh >= {1'b0, dsr_r};
    rem_sub = rem_sh - {1'b0, dsr_r};
    rem_nxt = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/fdmr_datapath.sv -----
module fdmr_datapath
  import fdmr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [PIX_W-1:0]       in_old_pixel,
  input  logic [PIX_W-1:0]       in_new_pixel,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic [PIX_W-1:0]       out_display_pixel,
  output logic                   out_frame_end,
  output logic                   out_motion_found,
  output logic [REGION_W-1:0]    out_region,
  output logic [OUT_COORD_W-1:0] out_center_x,
  output logic [OUT_COORD_W-1:0] out_center_y
);

  localparam logic [SIZE_EXT_W-1:0] SIZE_MAX = SIZE_EXT_W'(1) << COORD_BITS;

  function automatic logic [SIZE_EXT_W-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] n);
    logic [SIZE_EXT_W-1:0] n_x;
    begin
      n_x = SIZE_EXT_W'(n);
      if (n_x < SIZE_EXT_W'(3)) return SIZE_EXT_W'(3);
      if (n_x > SIZE_MAX) return SIZE_MAX;
      return n_x;
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] last_of(input logic [CFG_SIZE_W-1:0] n);
    logic [SIZE_EXT_W-1:0] sz;
    begin
      sz = clamp_size(n) - SIZE_EXT_W'(1);
      return sz[COORD_BITS-1:0];
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] third_of(input logic [CFG_SIZE_W-1:0] n);
    logic [DIV3_IN_W-1:0] q;
    begin
      q = div3(DIV3_IN_W'(clamp_size(n)));
      return q[COORD_BITS-1:0];
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] two_third_of(input logic [CFG_SIZE_W-1:0] n);
    logic [DIV3_IN_W-1:0] q;
    begin
      q = div3(DIV3_IN_W'({clamp_size(n), 1'b0}));
      return q[COORD_BITS-1:0];
    end
  endfunction

  function automatic logic [1:0] band(input logic [SUM_W-1:0] c,
                                      input logic [COORD_BITS-1:0] t1,
                                      input logic [COORD_BITS-1:0] t2);
    begin
      if (c < SUM_W'(t1)) return 2'd0;
      if (c < SUM_W'(t2)) return 2'd1;
      return 2'd2;
    end
  endfunction

  // configuration, kept in the derived form the pixel path needs
  logic [PIX_W-1:0]      thr_r;
  logic [CNT_W-1:0]      min_r;
  logic [COORD_BITS-1:0] w_last_r, w_t1_r, w_t2_r;
  logic [COORD_BITS-1:0] h_last_r, h_t1_r, h_t2_r;

  logic [COORD_BITS-1:0] col_r, row_r;
  logic [CNT_W-1:0]      count_r;
  logic [SUM_W-1:0]      sum_x_r, sum_y_r;
  logic [PIX_W-1:0]      pend_disp_r;

  logic [PIX_W-1:0]      disp_r;
  logic                  fend_r, motion_r;
  logic [REGION_W-1:0]   region_r;
  logic [OUT_COORD_W-1:0] cx_r, cy_r;

  logic [PIX_W-1:0] diff;
  logic             changed, on_grid, row_end, frame_last;
  logic [PIX_W-1:0] disp;
  logic [CNT_W-1:0] count_nxt;
  logic [SUM_W-1:0] sum_x_nxt, sum_y_nxt;
  logic             done_x, done_y;
  logic [SUM_W-1:0] quo_x, quo_y;
  logic [1:0]       band_x, band_y;
  logic [REGION_W-1:0] region;

  always_comb begin
    diff       = (in_old_pixel > in_new_pixel) ? in_old_pixel - in_new_pixel
                                               : in_new_pixel - in_old_pixel;
    changed    = diff > thr_r;
    on_grid    = (row_r == h_t1_r) || (row_r == h_t2_r) ||
                 (col_r == w_t1_r) || (col_r == w_t2_r);
    disp       = (changed || on_grid) ? PIX_MAX : in_new_pixel;
    row_end    = col_r >= w_last_r;
    frame_last = row_end && (row_r >= h_last_r);
    count_nxt  = (changed && (count_r != '1)) ? count_r + CNT_W'(1) : count_r;
    sum_x_nxt  = changed ? sum_x_r + SUM_W'(col_r) : sum_x_r;
    sum_y_nxt  = changed ? sum_y_r + SUM_W'(row_r) : sum_y_r;
  end

  assign status.frame_motion = frame_last && (count_nxt > min_r);
  assign status.div_done     = done_x && done_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= DEF_THRESHOLD;
      min_r    <= DEF_MIN_CHANGED;
      w_last_r <= last_of(DEF_WIDTH);
      w_t1_r   <= third_of(DEF_WIDTH);
      w_t2_r   <= two_third_of(DEF_WIDTH);
      h_last_r <= last_of(DEF_HEIGHT);
      h_t1_r   <= third_of(DEF_HEIGHT);
      h_t2_r   <= two_third_of(DEF_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIFF_THRESHOLD: thr_r <= cfg_wdata[PIX_W-1:0];
        CFG_MIN_CHANGED:    min_r <= cfg_wdata[CNT_W-1:0];
        CFG_FRAME_WIDTH: begin
          w_last_r <= last_of(cfg_wdata[CFG_SIZE_W-1:0]);
          w_t1_r   <= third_of(cfg_wdata[CFG_SIZE_W-1:0]);
          w_t2_r   <= two_third_of(cfg_wdata[CFG_SIZE_W-1:0]);
        end
        CFG_FRAME_HEIGHT: begin
          h_last_r <= last_of(cfg_wdata[CFG_SIZE_W-1:0]);
          h_t1_r   <= third_of(cfg_wdata[CFG_SIZE_W-1:0]);
          h_t2_r   <= two_third_of(cfg_wdata[CFG_SIZE_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  // raster position and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      count_r <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else if (cmd.step) begin
      if (frame_last) begin
        col_r   <= '0;
        row_r   <= '0;
        count_r <= '0;
        sum_x_r <= '0;
        sum_y_r <= '0;
      end else begin
        count_r <= count_nxt;
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
        if (row_end) begin
          col_r <= '0;
          row_r <= row_r + COORD_BITS'(1);
        end else begin
          col_r <= col_r + COORD_BITS'(1);
        end
      end
    end
  end

  fdmr_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_x_nxt),
    .divisor  (count_nxt),
    .done     (done_x),
    .quotient (quo_x)
  );

  fdmr_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_y_nxt),
    .divisor  (count_nxt),
    .done     (done_y),
    .quotient (quo_y)
  );

  always_comb begin
    band_x = band(quo_x, w_t1_r, w_t2_r);
    band_y = band(quo_y, h_t1_r, h_t2_r);
    region = REGION_W'({band_y, 1'b0}) + REGION_W'(band_y) + REGION_W'(band_x)
           + REGION_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      pend_disp_r <= disp;
    end
    if (cmd.load_pix) begin
      disp_r   <= disp;
      fend_r   <= frame_last;
      motion_r <= 1'b0;
      region_r <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
    end else if (cmd.load_div) begin
      disp_r   <= pend_disp_r;
      fend_r   <= 1'b1;
      motion_r <= 1'b1;
      region_r <= region;
      cx_r     <= quo_x[OUT_COORD_W-1:0];
      cy_r     <= quo_y[OUT_COORD_W-1:0];
    end
  end

  assign out_display_pixel = disp_r;
  assign out_frame_end     = fend_r;
  assign out_motion_found  = motion_r;
  assign out_region        = region_r;
  assign out_center_x      = cx_r;
  assign out_center_y      = cy_r;

endmodule

// ----- rtl/fdmr_ctrl.sv -----
module fdmr_ctrl
  import fdmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_PIXEL: begin
        if (cmd.div_start) state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_done) state_nxt = ST_PIXEL;
      end
      default: state_nxt = ST_PIXEL;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd           = '0;
    unique case (state_r)
      ST_PIXEL: begin
        in_stall      = !out_free;
        cmd.step      = in_valid && out_free;
        cmd.load_pix  = cmd.step && !status.frame_motion;
        cmd.div_start = cmd.step && status.frame_motion;
      end
      ST_DIVIDE: begin
        cmd.load_div = status.div_done;
      end
      default: ;
    endcase
    out_valid_nxt = (cmd.load_pix || cmd.load_div) || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_PIXEL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/frame_difference_motion_region_unit.sv -----
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+-------------------------------------------
// in       | input     | in_valid / in_stall | in_old_pixel, in_new_pixel
// out      | output    | out_valid/out_stall | out_display_pixel, out_frame_end,
//          |           |                     | out_motion_found, out_region, out_center_x/y
// cfg      | input     | cfg_we              | cfg_index, cfg_wdata
//
// A pixel request is taken every cycle while in_stall is low; its result is registered
// in the output register. The last pixel of a frame with motion holds the input while
// the two centroid dividers run one quotient bit per cycle over the 36-bit sums.
// Reset (rst_n low, synchronous) restores the default registers and clears position,
// count and sums. A stalled result holds the output register and stalls the input.
module frame_difference_motion_region_unit
  import fdmr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // pixel requests
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PIX_W-1:0]       in_old_pixel,
  input  logic [PIX_W-1:0]       in_new_pixel,
  // results
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PIX_W-1:0]       out_display_pixel,
  output logic                   out_frame_end,
  output logic                   out_motion_found,
  output logic [REGION_W-1:0]    out_region,
  output logic [OUT_COORD_W-1:0] out_center_x,
  output logic [OUT_COORD_W-1:0] out_center_y
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing: pixel acceptance, divider launch and result loading
  fdmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // pixel path, accumulators, dividers and result register
  fdmr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_old_pixel      (in_old_pixel),
    .in_new_pixel      (in_new_pixel),
    .cmd               (cmd),
    .status            (status),
    .out_display_pixel (out_display_pixel),
    .out_frame_end     (out_frame_end),
    .out_motion_found  (out_motion_found),
    .out_region        (out_region),
    .out_center_x      (out_center_x),
    .out_center_y      (out_center_y)
  );

  // launching the dividers frees the output register for the summary
  a_div_start_frees_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !out_valid)
    else $error("output still occupied while centroid division runs");

  // no pixel request may slip in while the dividers finish
  a_done_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> in_stall)
    else $error("input accepted during centroid division");

  // summary fields stay zero away from frame end
  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_end) |-> (!out_motion_found && out_region == '0))
    else $error("summary fields set off frame end");

  // a motion report always carries a region from one to nine
  a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_motion_found) |->
      (out_region != '0 && out_region <= REGION_W'(9)))
    else $error("region out of range on motion report");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import fdmr_pkg::*;

  // Cycles without any accepted request on either side before the run is declared hung.
  // The slowest correct gap is a frame end with motion (the centroid division) plus the
  // longest stall and send gap, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int COORD_W = COORD_BITS_DEF;

  typedef struct packed {
    logic [PIX_W-1:0] old_v;
    logic [PIX_W-1:0] new_v;
  } pixel_pair_t;

  typedef struct packed {
    logic [PIX_W-1:0]       display;
    logic                   frame_end;
    logic                   motion;
    logic [REGION_W-1:0]    region;
    logic [OUT_COORD_W-1:0] center_x;
    logic [OUT_COORD_W-1:0] center_y;
  } overlay_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_we = 1'b0;
  cfg_idx_e_t             cfg_index = CFG_DIFF_THRESHOLD;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [PIX_W-1:0]       in_old_pixel = '0;
  logic [PIX_W-1:0]       in_new_pixel = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PIX_W-1:0]       out_display_pixel;
  logic                   out_frame_end;
  logic                   out_motion_found;
  logic [REGION_W-1:0]    out_region;
  logic [OUT_COORD_W-1:0] out_center_x;
  logic [OUT_COORD_W-1:0] out_center_y;

  frame_difference_motion_region_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_old_pixel      (in_old_pixel),
    .in_new_pixel      (in_new_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_display_pixel (out_display_pixel),
    .out_frame_end     (out_frame_end),
    .out_motion_found  (out_motion_found),
    .out_region        (out_region),
    .out_center_x      (out_center_x),
    .out_center_y      (out_center_y)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Detector copy: registers as the block holds them, plus raster position and the motion
  // accumulators. Registers change only while no request is in flight.
  // ---------------------------------------------------------------------------------------
  logic [PIX_W-1:0]      threshold_reg  = DEF_THRESHOLD;
  logic [CNT_W-1:0]      min_count_reg  = DEF_MIN_CHANGED;
  logic [CFG_SIZE_W-1:0] width_reg      = DEF_WIDTH;
  logic [CFG_SIZE_W-1:0] height_reg     = DEF_HEIGHT;

  logic [COORD_W-1:0]    col_pos        = '0;
  logic [COORD_W-1:0]    row_pos        = '0;
  logic [CNT_W-1:0]      changed_cnt    = '0;
  logic [SUM_W-1:0]      col_sum        = '0;
  logic [SUM_W-1:0]      row_sum        = '0;

  pixel_pair_t pixel_req_q[$];
  overlay_t    expected_overlay_q[$];
  int          pixels_pending = 0;
  int          mismatches = 0;

  // Saturate a size register to what the raster counters can cover.
  function automatic int clamp_size(input logic [CFG_SIZE_W-1:0] n);
    if (n < 3) return 3;
    if (n > (1 << COORD_W)) return 1 << COORD_W;
    return int'(n);
  endfunction

  // Which third of an axis a centroid coordinate falls in; exactly 2n/3 is the outer third.
  function automatic int third_band(input longint c, input int n);
    if (c < n / 3) return 0;
    if (c < (2 * n) / 3) return 1;
    return 2;
  endfunction

  // Work out the overlay pixel (and frame summary on the last pixel) for one request,
  // and advance raster position and accumulators.
  task automatic predict_overlay(input pixel_pair_t p);
    int               w;
    int               h;
    int               d;
    logic [SUM_W-1:0] cx;
    logic [SUM_W-1:0] cy;
    overlay_t         res;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    d = int'(p.old_v) - int'(p.new_v);
    if (d < 0) d = -d;
    res = '0;
    if (d > int'(threshold_reg)) begin
      res.display = PIX_MAX;
      if (changed_cnt != '1) changed_cnt = changed_cnt + 1'b1;
      col_sum = col_sum + col_pos;
      row_sum = row_sum + row_pos;
    end else if (row_pos == h / 3 || row_pos == (2 * h) / 3 ||
                 col_pos == w / 3 || col_pos == (2 * w) / 3) begin
      // grid line at one and two thirds
      res.display = PIX_MAX;
    end else begin
      res.display = p.new_v;
    end

    // A row ends once the column reaches or passes the (possibly just shrunk) last column.
    if (int'(col_pos) >= w - 1) begin
      col_pos = '0;
      if (int'(row_pos) >= h - 1) begin
        res.frame_end = 1'b1;
        if (changed_cnt > min_count_reg) begin
          cx = col_sum / changed_cnt;
          cy = row_sum / changed_cnt;
          res.motion   = 1'b1;
          res.center_x = cx[OUT_COORD_W-1:0];
          res.center_y = cy[OUT_COORD_W-1:0];
          res.region   = REGION_W'(3 * third_band(cy, h) + third_band(cx, w) + 1);
        end
        row_pos     = '0;
        changed_cnt = '0;
        col_sum     = '0;
        row_sum     = '0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
    expected_overlay_q.push_back(res);
  endtask

  // Draw the idle cycles before the next request; now and then run a stretch with none.
  function automatic int next_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 5);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: pop the next pixel pair once the previous request is taken and its gap is over.
  // Predict at the edge where the request is accepted.
  // ---------------------------------------------------------------------------------------
  pixel_pair_t cur_pair;
  int          send_wait = 0;
  int          send_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_overlay(cur_pair);
        pixels_pending--;
      end
      // slot is free: either nothing was offered or the offer was just taken
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pixel_req_q.size() != 0) begin
          cur_pair     = pixel_req_q.pop_front();
          in_valid     <= 1'b1;
          in_old_pixel <= cur_pair.old_v;
          in_new_pixel <= cur_pair.new_v;
          send_wait    = next_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: take a result when not stalling, check it against the oldest prediction, then
  // hold stall for a freshly drawn number of cycles.
  // ---------------------------------------------------------------------------------------
  overlay_t seen;
  overlay_t want;
  int       hold_wait = 0;
  int       hold_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{out_display_pixel, out_frame_end, out_motion_found, out_region,
                 out_center_x, out_center_y};
        if (expected_overlay_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: pix=%0d fe=%0b mo=%0b reg=%0d cx=%0d cy=%0d",
                     seen.display, seen.frame_end, seen.motion, seen.region,
                     seen.center_x, seen.center_y);
        end else begin
          want = expected_overlay_q.pop_front();
          if (seen.display !== want.display || seen.frame_end !== want.frame_end ||
              seen.motion !== want.motion || seen.region !== want.region ||
              seen.center_x !== want.center_x || seen.center_y !== want.center_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("overlay mismatch: exp pix=%0d fe=%0b mo=%0b reg=%0d cx=%0d cy=%0d%s",
                       want.display, want.frame_end, want.motion, want.region,
                       want.center_x, want.center_y, "");
            if (mismatches <= 10)
              $display("                  got pix=%0d fe=%0b mo=%0b reg=%0d cx=%0d cy=%0d",
                       seen.display, seen.frame_end, seen.motion, seen.region,
                       seen.center_x, seen.center_y);
          end
        end
        hold_wait = next_gap(hold_calm);
      end
      if (hold_wait > 0) begin
        out_stall <= 1'b1;
        hold_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles with no accepted request on either channel.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------
  task automatic push_pair(input logic [PIX_W-1:0] o, input logic [PIX_W-1:0] n);
    pixel_req_q.push_back('{o, n});
    pixels_pending++;
  endtask

  // Wait until every request is taken and every result has come back, then let the
  // block drain before touching its registers.
  task automatic settle();
    while (pixels_pending != 0 || expected_overlay_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers on back-to-back cycles. Fill the unused upper data bits with
  // noise: the block must keep only the register's own width.
  task automatic program_regs(input logic [PIX_W-1:0] thr, input logic [CNT_W-1:0] minc,
                              input logic [CFG_SIZE_W-1:0] w, input logic [CFG_SIZE_W-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIFF_THRESHOLD;
    cfg_wdata <= {17'($urandom), thr};
    @(posedge clk);
    cfg_index <= CFG_MIN_CHANGED;
    cfg_wdata <= minc;
    @(posedge clk);
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= {12'($urandom), w};
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_wdata <= {12'($urandom), h};
    @(posedge clk);
    cfg_we    <= 1'b0;
    threshold_reg = thr;
    min_count_reg = minc;
    width_reg     = w;
    height_reg    = h;
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    int random_items;
    int w_eff;
    int h_eff;
    int frame_px;
    int n_pix;
    int k;
    int r;
    int c;
    int r0;
    int r1;
    int c0;
    int c1;
    int band_r;
    int band_c;
    bit has_blob;
    bit hot;
    logic [PIX_W-1:0]      thr;
    logic [CNT_W-1:0]      minc;
    logic [CFG_SIZE_W-1:0] w_set;
    logic [CFG_SIZE_W-1:0] h_set;
    logic [PIX_W-1:0]      lo;
    logic [PIX_W-1:0]      hi;
    logic [PIX_W-1:0]      base;
    logic [PIX_W-1:0]      step;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: difference exactly at the threshold stays, one above it is changed.
    push_pair(8'd100, 8'd130);
    push_pair(8'd100, 8'd131);
    push_pair(8'd0, 8'd255);
    settle();

    // Oversized frame saturates to the counter range; maximum threshold and maximum minimum
    // count let nothing through, so every pixel shows the new value.
    program_regs(8'd255, '1, 13'd8191, 13'd8191);
    push_pair(8'd255, 8'd0);
    push_pair(8'd0, 8'd255);
    push_pair(8'd170, 8'd85);
    push_pair(8'd85, 8'd170);
    settle();

    // Shrink to the smallest frame mid-row: the row ends at once. Zero threshold and zero
    // minimum count report motion from a handful of changed pixels.
    program_regs(8'd0, '0, 13'd0, 13'd1);
    push_pair(8'd0, 8'd0);
    push_pair(8'd1, 8'd0);
    push_pair(8'd0, 8'd1);
    push_pair(8'd128, 8'd127);
    push_pair(8'd0, 8'd0);
    push_pair(8'd255, 8'd255);
    push_pair(8'd37, 8'd200);
    // a still frame: no motion, summary stays zero
    for (k = 0; k < 9; k++) push_pair(8'(k * 29), 8'(k * 29));
    settle();

    // Random phases: new register setting, then mostly whole frames with a block of motion
    // in one of the nine cells, occasionally a partial frame left open for the next phase.
    random_items = 0;
    while (random_items < 450) begin
      case ($urandom_range(0, 9))
        0:       thr = '0;
        1:       thr = '1;
        default: thr = PIX_W'($urandom_range(5, 80));
      endcase
      w_set = ($urandom_range(0, 9) == 0) ? CFG_SIZE_W'($urandom_range(0, 2))
                                          : CFG_SIZE_W'($urandom_range(3, 12));
      h_set = ($urandom_range(0, 9) == 0) ? CFG_SIZE_W'($urandom_range(0, 2))
                                          : CFG_SIZE_W'($urandom_range(3, 9));
      w_eff = clamp_size(w_set);
      h_eff = clamp_size(h_set);
      frame_px = w_eff * h_eff;
      case ($urandom_range(0, 9))
        0:       minc = '0;
        1:       minc = '1;
        2:       minc = CNT_W'(24'hFFFFFF + 1);
        default: minc = CNT_W'($urandom_range(0, frame_px / 4));
      endcase
      program_regs(thr, minc, w_set, h_set);

      n_pix = $urandom_range(1, 3) * frame_px;
      if ($urandom_range(0, 5) == 0) n_pix += $urandom_range(1, frame_px - 1);

      for (k = 0; k < n_pix; k++) begin
        if (k % frame_px == 0) begin
          has_blob = ($urandom_range(0, 4) != 0);
          band_r = $urandom_range(0, 2);
          band_c = $urandom_range(0, 2);
          r0 = band_r * h_eff / 3;
          r1 = (band_r + 1) * h_eff / 3;
          c0 = band_c * w_eff / 3;
          c1 = (band_c + 1) * w_eff / 3;
        end
        r = (k / w_eff) % h_eff;
        c = k % w_eff;
        hot = (has_blob && r >= r0 && r < r1 && c >= c0 && c < c1) ||
              ($urandom_range(0, 15) == 0);
        if (hot) begin
          lo = PIX_W'($urandom_range(0, 90));
          hi = PIX_W'($urandom_range(170, 255));
          if ($urandom_range(0, 1)) push_pair(lo, hi);
          else push_pair(hi, lo);
        end else if ($urandom_range(0, 9) == 0) begin
          push_pair(PIX_W'($urandom), PIX_W'($urandom));
        end else begin
          base = PIX_W'($urandom);
          step = PIX_W'($urandom_range(0, 4));
          push_pair(base, (base > 8'd250) ? base - step : base + step);
        end
      end
      random_items += n_pix;
      settle();
    end

    // Drain, then give a late or spurious result time to show up.
    settle();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_overlay_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fdmr_pkg.sv
rtl/fdmr_div.sv
rtl/fdmr_datapath.sv
rtl/fdmr_ctrl.sv
rtl/frame_difference_motion_region_unit.sv
tb/tb_top.sv
